/* hdl/dfe_pkg.sv */
package dfe_pkg;

    localparam logic [1:0] CMD_LOAD   = 2'd0;
    localparam logic [1:0] CMD_UP     = 2'd1;
    localparam logic [1:0] CMD_DOWN   = 2'd2;
    localparam logic [1:0] CMD_SELECT = 2'd3;

    localparam logic [1:0] MODE_SPLASH   = 2'd0;
    localparam logic [1:0] MODE_NAVIGATE = 2'd1;
    localparam logic [1:0] MODE_EDIT     = 2'd2;

    localparam logic [1:0] SEL_YEAR  = 2'd0;
    localparam logic [1:0] SEL_MONTH = 2'd1;
    localparam logic [1:0] SEL_DAY   = 2'd2;

    localparam logic [13:0] YEAR_MAX = 14'd9999;

    localparam logic [4:0] MONTH_FIRST = 5'd1;
    localparam logic [4:0] MONTH_LAST  = 5'd12;

    localparam logic [4:0] DAYS_FEB_LEAP = 5'd29;
    localparam logic [4:0] DAYS_FEB      = 5'd28;
    localparam logic [4:0] DAYS_LONG     = 5'd31;
    localparam logic [4:0] DAYS_SHORT    = 5'd30;

    // 2^17 / 25 rounded up: exact for every 14-bit year
    localparam int          DIV25_SHIFT = 17;
    localparam logic [12:0] DIV25_RECIP = 13'd5243;

    typedef struct packed {
        logic [1:0]  command;
        logic [13:0] load_year;
        logic [3:0]  load_month;
        logic [4:0]  load_day;
    } cmd_item_t;

    typedef struct packed {
        logic [1:0]  screen;
        logic [1:0]  cursor;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
        logic        save;
    } res_item_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  field_sel;
        logic [13:0] year;
        logic [3:0]  month;
        logic [4:0]  day;
    } state_t;

    // gregorian rule; divisibility by 25 from the fraction of y * (2^17 / 25)
    function automatic logic is_leap(input logic [13:0] y);
        logic [26:0] prod;
        logic        div4;
        logic        div16;
        logic        div25;
        prod  = 27'(y) * 27'(DIV25_RECIP);
        div4  = (y[1:0] == 2'd0);
        div16 = (y[3:0] == 4'd0);
        div25 = (prod[DIV25_SHIFT-1:0] < DIV25_SHIFT'(DIV25_RECIP));
        return div4 && (!div25 || div16);
    endfunction

    // zero for a month outside 1..12
    function automatic logic [4:0] month_length(input logic [4:0] m, input logic leap);
        logic [4:0] len;
        unique case (m)
            5'd2:                                   len = leap ? DAYS_FEB_LEAP : DAYS_FEB;
            5'd1, 5'd3, 5'd5, 5'd7, 5'd8, 5'd10, 5'd12: len = DAYS_LONG;
            5'd4, 5'd6, 5'd9, 5'd11:                len = DAYS_SHORT;
            default:                                len = 5'd0;
        endcase
        return len;
    endfunction

endpackage

/* hdl/dfe_update.sv */
module dfe_update (
    input  dfe_pkg::cmd_item_t item,
    input  dfe_pkg::state_t    cur,
    output dfe_pkg::state_t    nxt,
    output logic               save
);

    logic        edit_up;
    logic [13:0] year_ed;
    logic [4:0]  month_ed;
    logic [5:0]  day_ed;
    logic [13:0] norm_year;
    logic [4:0]  norm_month_in;
    logic [5:0]  norm_day_in;
    logic [4:0]  len;
    logic [4:0]  norm_month;
    logic [5:0]  norm_day;

    assign edit_up = (item.command == dfe_pkg::CMD_UP);

    // step the chosen field; month and day keep a carry bit for the overflow case
    always_comb
    begin
        year_ed  = cur.year;
        month_ed = {1'b0, cur.month};
        day_ed   = {1'b0, cur.day};
        unique case (cur.field_sel)
            dfe_pkg::SEL_YEAR:
            begin
                priority if (cur.year > dfe_pkg::YEAR_MAX)
                    year_ed = dfe_pkg::YEAR_MAX;
                else if (edit_up)
                    year_ed = (cur.year < dfe_pkg::YEAR_MAX) ? cur.year + 14'd1
                                                             : dfe_pkg::YEAR_MAX;
                else
                    year_ed = (cur.year != 14'd0) ? cur.year - 14'd1 : 14'd0;
            end
            dfe_pkg::SEL_MONTH:
            begin
                month_ed = edit_up ? month_ed + 5'd1 : {1'b0, cur.month - 4'd1};
            end
            dfe_pkg::SEL_DAY:
            begin
                day_ed = edit_up ? day_ed + 6'd1 : {1'b0, cur.day - 5'd1};
            end
            default:
            begin
                year_ed = cur.year;
            end
        endcase
    end

    // select normalises the stored date as it stands
    always_comb
    begin
        if (item.command == dfe_pkg::CMD_SELECT)
        begin
            norm_year     = cur.year;
            norm_month_in = {1'b0, cur.month};
            norm_day_in   = {1'b0, cur.day};
        end
        else
        begin
            norm_year     = year_ed;
            norm_month_in = month_ed;
            norm_day_in   = day_ed;
        end
    end

    assign len = dfe_pkg::month_length(norm_month_in, dfe_pkg::is_leap(norm_year));

    // day checked against the unwrapped month, then month wrapped
    always_comb
    begin
        norm_day = norm_day_in;
        if (len != 5'd0)
        begin
            priority if (norm_day_in > {1'b0, len})
                norm_day = 6'd1;
            else if (norm_day_in == 6'd0)
                norm_day = {1'b0, len};
        end
        priority if (norm_month_in > dfe_pkg::MONTH_LAST)
            norm_month = dfe_pkg::MONTH_FIRST;
        else if (norm_month_in == 5'd0)
            norm_month = dfe_pkg::MONTH_LAST;
        else
            norm_month = norm_month_in;
    end

    always_comb
    begin
        nxt  = cur;
        save = 1'b0;
        priority if (item.command == dfe_pkg::CMD_LOAD)
        begin
            nxt.year  = item.load_year;
            nxt.month = item.load_month;
            nxt.day   = item.load_day;
        end
        else
        begin
            unique case (cur.mode)
                dfe_pkg::MODE_NAVIGATE:
                begin
                    unique case (item.command)
                        dfe_pkg::CMD_UP:
                            nxt.field_sel = (cur.field_sel == dfe_pkg::SEL_YEAR)
                                            ? dfe_pkg::SEL_DAY : cur.field_sel - 2'd1;
                        dfe_pkg::CMD_DOWN:
                            nxt.field_sel = cur.field_sel[1] ? dfe_pkg::SEL_YEAR
                                                             : cur.field_sel + 2'd1;
                        dfe_pkg::CMD_SELECT:
                            nxt.mode = dfe_pkg::MODE_EDIT;
                        default:
                            nxt.mode = cur.mode;
                    endcase
                end
                dfe_pkg::MODE_EDIT:
                begin
                    nxt.year  = norm_year;
                    nxt.month = norm_month[3:0];
                    nxt.day   = norm_day[4:0];
                    if (item.command == dfe_pkg::CMD_SELECT)
                    begin
                        nxt.mode = dfe_pkg::MODE_NAVIGATE;
                        save     = 1'b1;
                    end
                end
                default:
                begin
                    // splash, and the unused code behaves the same
                    if (item.command == dfe_pkg::CMD_SELECT)
                        nxt.mode = dfe_pkg::MODE_NAVIGATE;
                end
            endcase
        end
    end

endmodule

/* hdl/date_field_editor_core.sv */
// Date field editor: each item is a date load or an up, down or select key press, and
// gives one result with the screen mode, cursor, date and a save strobe. Throughput is
// one item per clock while the result output is not stalled: an item is registered on
// acceptance, and once the result register can take a value a single pass of combinational
// logic updates the mode, cursor and date registers and the result register together, so
// the following item already sees the new state. Items keep flowing while one result
// waits, until both the input and result registers are full.
module date_field_editor_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  dfe_pkg::cmd_item_t cmd_item,
    output logic               res_valid,
    input  logic               res_stall,
    output dfe_pkg::res_item_t res_item
);

    logic               in_valid_reg;
    logic               in_valid_next;
    dfe_pkg::cmd_item_t in_item_reg;
    logic               res_valid_reg;
    logic               res_valid_next;
    dfe_pkg::res_item_t res_item_reg;
    dfe_pkg::res_item_t res_item_next;
    dfe_pkg::state_t    state_reg;
    dfe_pkg::state_t    state_next;
    logic               upd_save;
    logic               res_open;
    logic               fire;
    logic               accept;

    assign res_open  = !res_valid_reg || !res_stall;
    assign fire      = in_valid_reg && res_open;
    assign cmd_stall = in_valid_reg && !res_open;
    assign accept    = cmd_valid && !cmd_stall;

    dfe_update u_update (
        .item (in_item_reg),
        .cur  (state_reg),
        .nxt  (state_next),
        .save (upd_save)
    );

    always_comb
    begin
        res_item_next.screen = state_next.mode;
        res_item_next.cursor = state_next.field_sel;
        res_item_next.year   = state_next.year;
        res_item_next.month  = state_next.month;
        res_item_next.day    = state_next.day;
        res_item_next.save   = upd_save;
    end

    always_comb
    begin
        priority if (accept)
            in_valid_next = 1'b1;
        else if (fire)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        priority if (fire)
            res_valid_next = 1'b1;
        else if (res_open)
            res_valid_next = 1'b0;
        else
            res_valid_next = res_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            res_valid_reg <= 1'b0;
            state_reg     <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            res_valid_reg <= res_valid_next;
            if (fire)
                state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            in_item_reg <= cmd_item;
        if (fire)
            res_item_reg <= res_item_next;
    end

    assign res_valid = res_valid_reg;
    assign res_item  = res_item_reg;

`ifndef NO_ASSERTIONS
    // a waiting result always mirrors the live state
    a_res_matches_state: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid_reg |-> (res_item_reg.screen == state_reg.mode &&
                           res_item_reg.cursor == state_reg.field_sel &&
                           res_item_reg.year == state_reg.year &&
                           res_item_reg.month == state_reg.month &&
                           res_item_reg.day == state_reg.day))
        else $error("result register out of step with state");

    a_save_leaves_edit: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && upd_save) |=> (state_reg.mode == dfe_pkg::MODE_NAVIGATE &&
                                $past(state_reg.mode) == dfe_pkg::MODE_EDIT))
        else $error("save strobe outside an edit exit");

    a_edit_month_wrapped: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && state_reg.mode == dfe_pkg::MODE_EDIT &&
         in_item_reg.command != dfe_pkg::CMD_LOAD)
        |=> (state_reg.month >= 4'd1 && state_reg.month <= 4'd12))
        else $error("month not normalised after edit");

    a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_stall |-> (in_valid_reg && res_valid_reg))
        else $error("input stalled with room to take an item");
`endif

endmodule

/* test/tb_date_field_editor_core.sv */
`timescale 1ns / 1ps

module tb_date_field_editor_core;

    localparam int unsigned IDLE_LIMIT   = 2000;
    localparam int          RANDOM_ITEMS = 1500;

    logic               clk       = 1'b0;
    logic               rst_n     = 1'b0;
    logic               cmd_valid = 1'b0;
    logic               cmd_stall;
    dfe_pkg::cmd_item_t cmd_item  = '0;
    logic               res_valid;
    logic               res_stall = 1'b0;
    dfe_pkg::res_item_t res_item;

    date_field_editor_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_item  (cmd_item),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_item  (res_item)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // predicted editor state, at reset values
    logic [1:0]  pred_mode  = dfe_pkg::MODE_SPLASH;
    logic [1:0]  pred_sel   = dfe_pkg::SEL_YEAR;
    logic [13:0] pred_year  = '0;
    logic [3:0]  pred_month = '0;
    logic [4:0]  pred_day   = '0;

    dfe_pkg::res_item_t expected_dates[$];
    int          errors       = 0;
    int          items_sent   = 0;
    int          results_seen = 0;
    int          saves_seen   = 0;
    int          edit_keys    = 0;
    int          burst_left   = 0;
    int unsigned idle_cycles  = 0;
    int          stall_left   = 0;
    int          stall_style  = 0;

    int notable_years[10] = '{0, 1, 1900, 2000, 2023, 2024, 2100, 2400, 9998, 9999};
    int boundary_days[7]  = '{0, 1, 28, 29, 30, 31, 15};

    function automatic int month_days(input int m, input int y);
        logic leap;
        leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        case (m)
            2:                     return leap ? 29 : 28;
            1, 3, 5, 7, 8, 10, 12: return 31;
            4, 6, 9, 11:           return 30;
            default:               return 0;
        endcase
    endfunction

    // day is checked against the unwrapped month, then the month wraps
    function automatic void wrap_date(inout int d, inout int m, input int y);
        int len;
        len = month_days(m, y);
        if (len != 0)
        begin
            if (d > len)
                d = 1;
            else if (d == 0)
                d = len;
        end
        if (m > int'(dfe_pkg::MONTH_LAST))
            m = int'(dfe_pkg::MONTH_FIRST);
        else if (m == 0)
            m = int'(dfe_pkg::MONTH_LAST);
    endfunction

    task automatic apply_event(input dfe_pkg::cmd_item_t it, output dfe_pkg::res_item_t r);
        int   y;
        int   m;
        int   d;
        logic save_now;
        save_now = 1'b0;
        y = int'(pred_year);
        m = int'(pred_month);
        d = int'(pred_day);
        if (it.command == dfe_pkg::CMD_LOAD)
        begin
            pred_year  = it.load_year;
            pred_month = it.load_month;
            pred_day   = it.load_day;
        end
        else if (pred_mode == dfe_pkg::MODE_NAVIGATE)
        begin
            case (it.command)
                dfe_pkg::CMD_UP:
                    pred_sel = (pred_sel == dfe_pkg::SEL_YEAR) ? dfe_pkg::SEL_DAY
                                                               : pred_sel - 2'd1;
                dfe_pkg::CMD_DOWN:
                    pred_sel = (pred_sel >= dfe_pkg::SEL_DAY) ? dfe_pkg::SEL_YEAR
                                                              : pred_sel + 2'd1;
                default:
                    pred_mode = dfe_pkg::MODE_EDIT;
            endcase
        end
        else if (pred_mode == dfe_pkg::MODE_EDIT)
        begin
            edit_keys++;
            if (it.command == dfe_pkg::CMD_SELECT)
            begin
                wrap_date(d, m, y);
                pred_mode = dfe_pkg::MODE_NAVIGATE;
                save_now  = 1'b1;
            end
            else
            begin
                case (pred_sel)
                    dfe_pkg::SEL_YEAR:
                    begin
                        if (y > int'(dfe_pkg::YEAR_MAX))
                            y = int'(dfe_pkg::YEAR_MAX);
                        else if (it.command == dfe_pkg::CMD_UP)
                            y = (y < int'(dfe_pkg::YEAR_MAX)) ? y + 1
                                                              : int'(dfe_pkg::YEAR_MAX);
                        else
                            y = (y > 0) ? y - 1 : 0;
                    end
                    dfe_pkg::SEL_MONTH:
                        m = (it.command == dfe_pkg::CMD_UP) ? m + 1 : ((m - 1) & 15);
                    dfe_pkg::SEL_DAY:
                        d = (it.command == dfe_pkg::CMD_UP) ? d + 1 : ((d - 1) & 31);
                    default:   ;
                endcase
                wrap_date(d, m, y);
                pred_year = y[13:0];
            end
            pred_month = m[3:0];
            pred_day   = d[4:0];
        end
        else if (it.command == dfe_pkg::CMD_SELECT)
        begin
            pred_mode = dfe_pkg::MODE_NAVIGATE;
        end
        r.screen = pred_mode;
        r.cursor = pred_sel;
        r.year   = pred_year;
        r.month  = pred_month;
        r.day    = pred_day;
        r.save   = save_now;
    endtask

    task automatic check_field(input string name, input logic [13:0] want,
                               input logic [13:0] seen);
        if (seen !== want)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, seen);
        end
    endtask

    // prediction first, so any latency lines up with the queue
    always @(posedge clk)
    begin
        dfe_pkg::res_item_t fresh;
        dfe_pkg::res_item_t want;
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                apply_event(cmd_item, fresh);
                expected_dates.push_back(fresh);
            end
            if (res_valid && !res_stall)
            begin
                results_seen++;
                if (expected_dates.size() == 0)
                begin
                    errors++;
                    $display("%0t ns: result with nothing expected, actual %h", $time, res_item);
                end
                else
                begin
                    want = expected_dates.pop_front();
                    if (want.save)
                        saves_seen++;
                    check_field("screen", 14'(want.screen), 14'(res_item.screen));
                    check_field("cursor", 14'(want.cursor), 14'(res_item.cursor));
                    check_field("year", want.year, res_item.year);
                    check_field("month", 14'(want.month), 14'(res_item.month));
                    check_field("day", 14'(want.day), 14'(res_item.day));
                    check_field("save", 14'(want.save), 14'(res_item.save));
                end
            end
        end
    end

    // receiver back-pressure: free running, random, periodic or heavy
    always @(negedge clk)
    begin
        if (stall_left == 0)
        begin
            stall_style = $urandom_range(0, 3);
            stall_left  = $urandom_range(20, 150);
        end
        else
        begin
            stall_left--;
        end
        case (stall_style)
            0:       res_stall <= 1'b0;
            1:       res_stall <= ($urandom_range(0, 99) < 30);
            2:       res_stall <= ((stall_left % 5) < 2);
            default: res_stall <= ($urandom_range(0, 99) < 85);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || (cmd_valid && !cmd_stall) || (res_valid && !res_stall))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles == IDLE_LIMIT)
        begin
            $display("%0t ns: no handshake for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_date_field_editor_core: errors");
            $finish;
        end
    end

    // called at a falling edge, returns at the falling edge after acceptance
    task automatic send_item(input dfe_pkg::cmd_item_t it);
        int gap;
        if (burst_left == 0)
        begin
            gap        = $urandom_range(0, 5);
            burst_left = ($urandom_range(0, 9) == 0) ? 200 : $urandom_range(1, 30);
            if (gap != 0)
            begin
                cmd_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
        end
        cmd_item  <= it;
        cmd_valid <= 1'b1;
        @(posedge clk);
        while (cmd_stall)
            @(posedge clk);
        burst_left--;
        items_sent++;
        @(negedge clk);
    endtask

    // load fields carry noise on key presses
    task automatic send_key(input logic [1:0] cmd);
        dfe_pkg::cmd_item_t it;
        it         = dfe_pkg::cmd_item_t'($urandom);
        it.command = cmd;
        send_item(it);
    endtask

    task automatic send_load(input logic [13:0] y, input logic [3:0] m, input logic [4:0] d);
        dfe_pkg::cmd_item_t it;
        it.command    = dfe_pkg::CMD_LOAD;
        it.load_year  = y;
        it.load_month = m;
        it.load_day   = d;
        send_item(it);
    endtask

    task automatic test_splash_keys();
        send_key(dfe_pkg::CMD_UP);
        send_key(dfe_pkg::CMD_DOWN);
        send_load(14'h3fff, 4'hf, 5'h1f);
    endtask

    task automatic test_cursor_moves();
        send_key(dfe_pkg::CMD_SELECT);
        send_key(dfe_pkg::CMD_UP);
        send_key(dfe_pkg::CMD_DOWN);
    endtask

    // year above range snaps to max, then saturation at both ends
    task automatic test_year_edit();
        send_key(dfe_pkg::CMD_SELECT);
        send_key(dfe_pkg::CMD_UP);
        send_key(dfe_pkg::CMD_UP);
        send_load(14'd0, 4'd0, 5'd0);
        send_key(dfe_pkg::CMD_DOWN);
        send_key(dfe_pkg::CMD_SELECT);
    endtask

    task automatic test_month_edit();
        send_key(dfe_pkg::CMD_DOWN);
        send_key(dfe_pkg::CMD_SELECT);
        send_load(14'd2023, 4'd0, 5'd31);
        send_key(dfe_pkg::CMD_DOWN);
        send_key(dfe_pkg::CMD_UP);
        send_key(dfe_pkg::CMD_SELECT);
    endtask

    // day 31 up in a bad month wraps to zero; zero down wraps to 31
    task automatic test_day_edit();
        send_key(dfe_pkg::CMD_DOWN);
        send_key(dfe_pkg::CMD_SELECT);
        send_load(14'd2023, 4'd0, 5'd31);
        send_key(dfe_pkg::CMD_UP);
        send_key(dfe_pkg::CMD_DOWN);
        send_key(dfe_pkg::CMD_UP);
    endtask

    task automatic test_leap_years();
        send_load(14'd2000, 4'd2, 5'd28);
        send_key(dfe_pkg::CMD_UP);
        send_load(14'd1900, 4'd2, 5'd28);
        send_key(dfe_pkg::CMD_UP);
    endtask

    task automatic send_random_load();
        logic [13:0] y;
        logic [3:0]  m;
        logic [4:0]  d;
        int          pick;
        pick = $urandom_range(0, 9);
        if (pick < 3)
            y = 14'($urandom);
        else if (pick < 6)
            y = 14'(notable_years[$urandom_range(0, 9)]);
        else
            y = 14'($urandom_range(0, 9999));
        m = ($urandom_range(0, 9) < 7) ? 4'($urandom_range(1, 12)) : 4'($urandom);
        d = ($urandom_range(0, 1) == 1) ? 5'(boundary_days[$urandom_range(0, 6)])
                                        : 5'($urandom);
        send_load(y, m, d);
    endtask

    // steer by predicted mode so most presses land in navigate and edit
    task automatic test_random();
        int roll;
        int key;
        repeat (RANDOM_ITEMS)
        begin
            roll = $urandom_range(0, 99);
            key  = $urandom_range(0, 9);
            if (roll < 15)
                send_random_load();
            else if (pred_mode == dfe_pkg::MODE_EDIT)
                send_key(key < 4 ? dfe_pkg::CMD_UP :
                         key < 8 ? dfe_pkg::CMD_DOWN : dfe_pkg::CMD_SELECT);
            else if (pred_mode == dfe_pkg::MODE_NAVIGATE)
                send_key(key < 3 ? dfe_pkg::CMD_UP :
                         key < 6 ? dfe_pkg::CMD_DOWN : dfe_pkg::CMD_SELECT);
            else
                send_key(key < 8 ? dfe_pkg::CMD_SELECT :
                         (key == 8 ? dfe_pkg::CMD_UP : dfe_pkg::CMD_DOWN));
        end
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);
        test_splash_keys();
        test_cursor_moves();
        test_year_edit();
        test_month_edit();
        test_day_edit();
        test_leap_years();
        test_random();
        cmd_valid <= 1'b0;
        while (expected_dates.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
        $display("run covered %0d items and %0d checked results, %0d of them saves",
                 items_sent, results_seen, saves_seen);
        $display("%0d key presses were handled in edit mode", edit_keys);
        if (errors == 0)
            $display("tb_date_field_editor_core: clean");
        else
            $display("tb_date_field_editor_core: errors");
        $finish;
    end

endmodule
